### rtl/three_phase_minmax_pwm_compare_assert.svh
// Assertion macros shared by the compare block.
`ifndef THREE_PHASE_MINMAX_PWM_COMPARE_ASSERT_SVH
`define THREE_PHASE_MINMAX_PWM_COMPARE_ASSERT_SVH

// Checks that a consequence holds in the same cycle as its cause.
`define TPMM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compare block check failed");

// Checks that a consequence holds in the cycle after its cause.
`define TPMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("compare block check failed");

`endif

### rtl/tpmm_pkg.sv
// Shared types and constants for the three-phase compare pipeline.
`timescale 1ns / 1ps
`default_nettype none

package tpmm_pkg;

  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int QUOT_W    = 17;
  localparam int DIV_STEPS = QUOT_W;
  localparam int DUTY_W    = 19;

  localparam logic [16:0] DUTY_ONE = 17'h10000;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_OFF = 2'd1;
  localparam logic [1:0] OP_ON  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUS_VOLTAGE     = 3'd0,
    CFG_MIN_BUS_VOLTAGE = 3'd1,
    CFG_DUTY_LIMIT      = 3'd2,
    CFG_DUTY_CENTER     = 3'd3,
    CFG_PWM_PERIOD      = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] RESET_BUS_VOLTAGE     = 16'd6144;
  localparam logic [15:0] RESET_MIN_BUS_VOLTAGE = 16'd2560;
  localparam logic [15:0] RESET_DUTY_LIMIT      = 16'd62259;
  localparam logic [15:0] RESET_DUTY_CENTER     = 16'd32768;
  localparam logic [15:0] RESET_PWM_PERIOD      = 16'd4095;

  // Register values as seen by the datapath; divisor is already floored.
  typedef struct packed {
    logic [15:0] divisor;
    logic [15:0] limit;
    logic [15:0] center;
    logic [15:0] period;
  } cfg_t;

  // One phase-triple word as it travels through the divider.
  typedef struct packed {
    logic             off;
    logic [15:0]      mid;
    logic [2:0]       neg;
    logic [2:0]       ovf;
    logic [2:0][1:0]  lo;
    logic [2:0][15:0] rem;
    logic [2:0][16:0] quo;
  } div_t;

endpackage

`default_nettype wire

### rtl/three_phase_minmax_pwm_compare.sv
// Top level of the three-phase min/max injection PWM compare generator.
//
// Input channel: in_valid/in_stall carry one word per accepted edge: an op
// code and three signed Q8.8 phase voltages. Output channel: out_valid and
// out_stall carry one word per input word: three timer compare counts and
// the max/min midpoint voltage. Results leave in the order items came in.
// The pipeline has 24 register stages: 3 input stages (extremes, centered
// differences, magnitudes), 17 divider stages that each resolve one quotient
// bit for all three phases, and 4 output stages (duty sum, clamp, period
// multiply, output register). It takes one word per cycle while in_stall
// is low; the divider chain is what sets the depth.
// When the receiver stalls, stages holding a word freeze while empty
// stages keep filling, so new words are still taken until the pipeline is
// full; in_stall rises only when every stage holds a word.
// The configuration port takes a write at any edge with cfg_write high. It
// may be written only while the pipeline is empty. Reset empties the
// pipeline and loads all five registers with their default values; the
// divisor register is reset too, then registers the larger voltage setting.
`timescale 1ns / 1ps
`default_nettype none
`include "three_phase_minmax_pwm_compare_assert.svh"

module three_phase_minmax_pwm_compare import tpmm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port.
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  // Input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           op,
  input  wire logic signed [15:0]   volt_u,
  input  wire logic signed [15:0]   volt_v,
  input  wire logic signed [15:0]   volt_w,
  // Output channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               compare_u,
  output logic [15:0]               compare_v,
  output logic [15:0]               compare_w,
  output logic signed [15:0]        mid_voltage
);

  cfg_t cfg;

  // Front end to divider.
  logic front_valid;
  div_t front_data;
  logic div_in_en;

  // Divider to back end.
  logic div_valid;
  div_t div_data;
  logic back_in_en;

  tpmm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Each section advances a stage when it is empty or the next one moves.
  tpmm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .volt_u   (volt_u),
    .volt_v   (volt_v),
    .volt_w   (volt_w),
    .cfg      (cfg),
    .nxt_en   (div_in_en),
    .o_valid  (front_valid),
    .o_data   (front_data)
  );

  tpmm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .i_valid (front_valid),
    .i_data  (front_data),
    .i_en    (div_in_en),
    .divisor (cfg.divisor),
    .nxt_en  (back_in_en),
    .o_valid (div_valid),
    .o_data  (div_data)
  );

  tpmm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .i_valid     (div_valid),
    .i_data      (div_data),
    .i_en        (back_in_en),
    .cfg         (cfg),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .compare_u   (compare_u),
    .compare_v   (compare_v),
    .compare_w   (compare_w),
    .mid_voltage (mid_voltage)
  );

  // The input can only be held off when the whole pipeline backs up from
  // a stalled, full output register.
  `TPMM_ASSERT_NOW(a_stall_from_output, in_stall, out_valid && out_stall)

  // The divider never sees a zero divisor.
  `TPMM_ASSERT_NOW(a_divisor_nonzero, 1'b1, cfg.divisor != '0)

  // Reset leaves the output empty.
  `TPMM_ASSERT_NOW(a_reset_empties, $past(rst), !out_valid)

endmodule

`default_nettype wire

### rtl/tpmm_cfg.sv
// Configuration registers and divisor selection.
`timescale 1ns / 1ps
`default_nettype none

module tpmm_cfg import tpmm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  output cfg_t                      cfg
);

  logic [15:0] bus;
  logic [15:0] min_bus;
  logic [15:0] limit;
  logic [15:0] center;
  logic [15:0] period;
  logic [15:0] divisor;
  logic [15:0] divisor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus     <= RESET_BUS_VOLTAGE;
      min_bus <= RESET_MIN_BUS_VOLTAGE;
      limit   <= RESET_DUTY_LIMIT;
      center  <= RESET_DUTY_CENTER;
      period  <= RESET_PWM_PERIOD;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BUS_VOLTAGE:     bus     <= cfg_data;
        CFG_MIN_BUS_VOLTAGE: min_bus <= cfg_data;
        CFG_DUTY_LIMIT:      limit   <= cfg_data;
        CFG_DUTY_CENTER:     center  <= cfg_data;
        CFG_PWM_PERIOD:      period  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The larger of the two voltages, never zero.
  always_comb begin
    divisor_next = (bus > min_bus) ? bus : min_bus;
    if (divisor_next == '0) begin
      divisor_next = 16'd1;
    end
  end

  // The bus reset value is the larger of the two reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= RESET_BUS_VOLTAGE;
    end else begin
      divisor <= divisor_next;
    end
  end

  assign cfg.divisor = divisor;
  assign cfg.limit   = limit;
  assign cfg.center  = center;
  assign cfg.period  = period;

endmodule

`default_nettype wire

### rtl/tpmm_front.sv
// Input stages: max and min search, centered differences and magnitudes.
`timescale 1ns / 1ps
`default_nettype none

module tpmm_front import tpmm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic signed [15:0] volt_u,
  input  wire logic signed [15:0] volt_v,
  input  wire logic signed [15:0] volt_w,
  input  wire cfg_t               cfg,
  input  wire logic               nxt_en,
  output logic                    o_valid,
  output div_t                    o_data
);

  logic               en1, en2, en3;
  logic               v1, v2, v3;

  // Stage 1: registered inputs plus extremes.
  logic               off1, on1;
  logic signed [15:0] x1 [3];
  logic signed [15:0] mx1, mn1;
  logic signed [15:0] mx_uv, mn_uv, mx_next, mn_next;

  // Stage 2: centered differences in half-LSB units.
  logic               off2;
  logic [15:0]        mid2;
  logic signed [17:0] n2 [3];
  logic signed [16:0] sum1;
  logic signed [17:0] n_next [3];
  logic [15:0]        mid_next;

  // Stage 3: sign, magnitude and divider seed.
  div_t               st3;
  div_t               st3_next;

  assign en3      = !v3 || nxt_en;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_comb begin
    mx_uv   = (volt_u > volt_v) ? volt_u : volt_v;
    mn_uv   = (volt_u < volt_v) ? volt_u : volt_v;
    mx_next = (mx_uv > volt_w) ? mx_uv : volt_w;
    mn_next = (mn_uv < volt_w) ? mn_uv : volt_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      off1  <= (op != OP_SET) && (op != OP_ON);
      on1   <= (op == OP_ON);
      x1[0] <= volt_u;
      x1[1] <= volt_v;
      x1[2] <= volt_w;
      mx1   <= mx_next;
      mn1   <= mn_next;
    end
  end

  // Power on forces every difference to zero so the duty is the center.
  always_comb begin
    sum1 = $signed({mx1[15], mx1}) + $signed({mn1[15], mn1});
    for (int i = 0; i < 3; i++) begin
      n_next[i] = on1 ? '0 : ($signed({x1[i][15], x1[i], 1'b0}) - $signed({sum1[16], sum1}));
    end
    if (off1) begin
      mid_next = '0;
    end else if (on1) begin
      mid_next = {8'd0, cfg.center[15:8]};
    end else begin
      mid_next = sum1[16:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      off2 <= off1;
      mid2 <= mid_next;
      for (int i = 0; i < 3; i++) begin
        n2[i] <= n_next[i];
      end
    end
  end

  // The magnitude never exceeds the max-min spread, so 16 bits hold it.
  // A quotient of 2^17 or more is flagged and saturated later.
  always_comb begin
    logic signed [17:0] neg_n;
    logic [15:0]        mag;
    st3_next     = '0;
    st3_next.off = off2;
    st3_next.mid = mid2;
    for (int i = 0; i < 3; i++) begin
      neg_n              = -n2[i];
      mag                = n2[i][17] ? neg_n[15:0] : n2[i][15:0];
      st3_next.neg[i]    = n2[i][17];
      st3_next.ovf[i]    = ({2'b00, mag} >= {cfg.divisor, 2'b00});
      st3_next.lo[i]     = mag[1:0];
      st3_next.rem[i]    = {2'b00, mag[15:2]};
      st3_next.quo[i]    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      st3 <= st3_next;
    end
  end

  assign o_valid = v3;
  assign o_data  = st3;

endmodule

`default_nettype wire

### rtl/tpmm_div.sv
// Restoring divider, one quotient bit per stage for all three phases.
`timescale 1ns / 1ps
`default_nettype none

module tpmm_div import tpmm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        i_valid,
  input  wire div_t        i_data,
  output logic             i_en,
  input  wire logic [15:0] divisor,
  input  wire logic        nxt_en,
  output logic             o_valid,
  output div_t             o_data
);

  // The dividend is the magnitude times 2^15: its two low bits come in
  // first, then zeros.
  function automatic div_t div_step(div_t a, logic [15:0] d, logic [4:0] step);
    div_t        r;
    logic        b;
    logic [16:0] t;
    logic [16:0] diff;
    r = a;
    for (int i = 0; i < 3; i++) begin
      if (step == 5'd0) begin
        b = a.lo[i][1];
      end else if (step == 5'd1) begin
        b = a.lo[i][0];
      end else begin
        b = 1'b0;
      end
      t    = {a.rem[i], b};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
        r.rem[i] = diff[15:0];
        r.quo[i] = {a.quo[i][15:0], 1'b1};
      end else begin
        r.rem[i] = t[15:0];
        r.quo[i] = {a.quo[i][15:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [DIV_STEPS:0]   en_chain;
  logic [DIV_STEPS-1:0] vld;
  div_t                 st [DIV_STEPS];

  assign en_chain[DIV_STEPS] = nxt_en;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic prev_valid;
    div_t prev_data;

    if (k == 0) begin : g_first
      assign prev_valid = i_valid;
      assign prev_data  = i_data;
    end else begin : g_rest
      assign prev_valid = vld[k-1];
      assign prev_data  = st[k-1];
    end

    assign en_chain[k] = !vld[k] || en_chain[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en_chain[k]) begin
        vld[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en_chain[k]) begin
        st[k] <= div_step(prev_data, divisor, 5'(k));
      end
    end
  end

  assign i_en    = en_chain[0];
  assign o_valid = vld[DIV_STEPS-1];
  assign o_data  = st[DIV_STEPS-1];

endmodule

`default_nettype wire

### rtl/tpmm_back.sv
// Output stages: duty sum, clamp, period scaling and the output register.
`timescale 1ns / 1ps
`default_nettype none

module tpmm_back import tpmm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  i_valid,
  input  wire div_t  i_data,
  output logic       i_en,
  input  wire cfg_t  cfg,
  input  wire logic  out_stall,
  output logic       out_valid,
  output logic [15:0] compare_u,
  output logic [15:0] compare_v,
  output logic [15:0] compare_w,
  output logic signed [15:0] mid_voltage
);

  logic en1, en2, en3, en4;
  logic v1, v2, v3, v4;

  logic                     off1, off2, off3;
  logic [15:0]              mid1, mid2, mid3;
  logic signed [DUTY_W-1:0] duty1 [3];
  logic [16:0]              rest2 [3];
  logic [32:0]              prod3 [3];
  logic [15:0]              cmp4  [3];
  logic [15:0]              mid4;

  logic signed [DUTY_W-1:0] duty_next [3];
  logic [16:0]              rest_next [3];
  logic [16:0]              lower;

  assign en4  = !v4 || !out_stall;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign i_en = en1;

  // A flagged quotient saturates; it lands on a clamp either way.
  always_comb begin
    logic [16:0]              qs;
    logic signed [DUTY_W-1:0] sq;
    for (int i = 0; i < 3; i++) begin
      qs = i_data.ovf[i] ? '1 : i_data.quo[i];
      sq = i_data.neg[i] ? -$signed({2'b00, qs}) : $signed({2'b00, qs});
      duty_next[i] = $signed({3'b000, cfg.center}) + sq;
    end
  end

  // The lower clamp is tested first, which matters when the limits cross.
  always_comb begin
    logic [16:0] cl;
    lower = DUTY_ONE - {1'b0, cfg.limit};
    for (int i = 0; i < 3; i++) begin
      if (duty1[i] < $signed({2'b00, lower})) begin
        cl = lower;
      end else if (duty1[i] > $signed({3'b000, cfg.limit})) begin
        cl = {1'b0, cfg.limit};
      end else begin
        cl = duty1[i][16:0];
      end
      rest_next[i] = DUTY_ONE - cl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= i_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      off1 <= i_data.off;
      mid1 <= i_data.mid;
      for (int i = 0; i < 3; i++) begin
        duty1[i] <= duty_next[i];
      end
    end
    if (en2) begin
      off2 <= off1;
      mid2 <= mid1;
      for (int i = 0; i < 3; i++) begin
        rest2[i] <= rest_next[i];
      end
    end
    if (en3) begin
      off3 <= off2;
      mid3 <= mid2;
      for (int i = 0; i < 3; i++) begin
        prod3[i] <= 33'(rest2[i]) * 33'(cfg.period);
      end
    end
    if (en4) begin
      mid4 <= mid3;
      for (int i = 0; i < 3; i++) begin
        cmp4[i] <= off3 ? '0 : prod3[i][31:16];
      end
    end
  end

  assign out_valid   = v4;
  assign compare_u   = cmp4[0];
  assign compare_v   = cmp4[1];
  assign compare_w   = cmp4[2];
  assign mid_voltage = $signed(mid4);

endmodule

`default_nettype wire
